[src/pch_pkg.sv]
// Package: constants and types for the per-channel histogram block.
package pch_pkg;
    localparam int NUM_CHANNELS = 64;
    localparam int MAX_BINS     = 256;
    localparam int SAMPLE_BITS  = 16;
    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int ADDR_W = CH_W + BIN_W;
    localparam int DEPTH  = NUM_CHANNELS * MAX_BINS;
    localparam int CNT_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    // Numerator width: (sample - min) * bins, bins up to 256.
    localparam int NUM_W  = 16 + 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS = 2'd2;

    localparam logic FUNC_ACC  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_DIV, ST_READ, ST_WRITE, ST_OUT
    } t_state;

    typedef struct packed {
        logic       func;
        logic [5:0] channel;
        logic [15:0] sample;
        logic [7:0] read_bin;
        logic       clear_max;
    } t_in;

    typedef struct packed {
        logic [7:0]  bin_index;
        logic [31:0] bin_count;
        logic [31:0] max_seen;
        logic        out_of_range;
    } t_out;
endpackage

[src/pch_if.sv]
// Interface: valid/ready channel carrying one payload.
interface pch_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source  (output valid, output data, input ready);
    modport sink    (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

[src/pch_div.sv]
// Restoring divider, one quotient bit per cycle.
module pch_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [pch_pkg::NUM_W-1:0] i_num,
    input  logic [15:0]             i_den,
    output logic                    o_done,
    output logic [pch_pkg::NUM_W-1:0] o_quo,
    output logic                    o_exact
);
    import pch_pkg::*;
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [16:0]      r_rem;
    logic [15:0]      r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [16:0]      w_trial;
    logic [16:0]      w_sub;

    assign w_trial = {r_rem[15:0], r_quo[NUM_W-1]};
    assign w_sub   = w_trial - {1'b0, r_den};

    // shift in one numerator bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_sub[16]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) r_busy <= 1'b0;
            end
        end
    end

    assign o_done  = r_done;
    assign o_quo   = r_quo;
    assign o_exact = (r_rem == '0);
endmodule

[src/per_channel_histogram_with_max.sv]
// Top level: per-channel histogram store with running maximum.
// Path from accept to output valid: an accumulate goes through the 25-bit bit-serial divider,
// store read, write and output; a dropped sample goes straight to output; read-and-clear via read, write, output.
// Throughput: one item at a time; the next accept waits until the state returns to idle once
// the result registers in the output state, and an output stall holds that off.
// Reset: synchronous active low; a clearing pass zeroes every counter first.
module per_channel_histogram_with_max (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pch_if.sink                    i_in,
    pch_if.source                  o_out,
    input  logic                   i_cfg_we,
    input  logic [pch_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pch_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import pch_pkg::*;

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rdata;

    logic [15:0] r_min, r_max;
    logic [8:0]  r_bins;
    t_state      r_state, n_state;
    t_in         r_item;
    t_out        r_res;
    logic        r_ovalid;
    logic [31:0] r_rmax;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr;
    logic [BIN_W-1:0]  r_q;
    logic        r_started;

    logic [8:0]  w_nb;
    logic [15:0] w_span;
    logic [NUM_W-1:0] w_num;
    logic        w_oor;
    logic        w_ch_ok;
    logic        w_rd_ok;
    logic        w_kick;
    logic        w_start;
    logic        w_done;
    logic [NUM_W-1:0] w_quo;
    logic        w_exact;
    logic [NUM_W-1:0] w_qadj;
    logic [31:0] w_inc;
    logic [31:0] w_mbase;
    logic        w_take;
    logic        w_mwe;
    logic        w_mre;
    logic [ADDR_W-1:0] w_maddr;
    logic [CNT_W-1:0]  w_mdata;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= 16'd0;
            r_max  <= 16'hFFFF;
            r_bins <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN:  r_min  <= i_cfg_data;
                CFG_MAX:  r_max  <= i_cfg_data;
                CFG_BINS: r_bins <= i_cfg_data[8:0];
                default:  ;
            endcase
        end
    end

    assign w_nb   = (r_bins == 9'd0) ? 9'd1 :
                    (r_bins > 9'(MAX_BINS)) ? 9'(MAX_BINS) : r_bins;
    assign w_span = r_max - r_min;
    assign w_num  = NUM_W'(r_item.sample - r_min) * NUM_W'(w_nb);
    assign w_oor  = (r_max <= r_min) || (r_item.sample < r_min) ||
                    (r_item.sample > r_max);

    // address checks against the store size
    assign w_ch_ok = ({1'b0, r_item.channel} < (CH_W+1)'(NUM_CHANNELS));
    assign w_rd_ok = w_ch_ok && ({1'b0, r_item.read_bin} < (BIN_W+1)'(MAX_BINS));

    pch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_span),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_exact (w_exact)
    );

    // divider start is one pulse on entering ST_DIV, unless the item is dropped
    assign w_kick  = (r_state == ST_DIV) && !r_started && !w_oor && w_ch_ok;
    assign w_start = w_kick;

    // bin adjust: exact positive quotient drops by one, then clamp
    always_comb begin
        w_qadj = w_quo;
        if (w_quo != '0 && w_exact) w_qadj = w_quo - 1'b1;
        if (w_qadj >= NUM_W'(w_nb)) w_qadj = NUM_W'(w_nb) - 1'b1;
    end

    assign w_take  = i_in.valid && i_in.ready;
    assign w_mbase = r_item.clear_max ? 32'd0 : r_rmax;
    assign w_inc   = (r_rdata == 32'hFFFFFFFF) ? r_rdata : r_rdata + 32'd1;
    assign w_mre   = (r_state == ST_READ);

    // next state and memory controls
    always_comb begin
        n_state = r_state;
        w_mwe   = 1'b0;
        w_maddr = r_addr;
        w_mdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mwe   = 1'b1;
                w_maddr = r_clr;
                if (r_clr == ADDR_W'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: if (w_take) n_state = (i_in.data.func == FUNC_READ) ? ST_READ : ST_DIV;
            ST_DIV: begin
                if (w_oor || !w_ch_ok) begin
                    n_state = ST_OUT;
                end else if (r_started && w_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_item.func == FUNC_READ && w_rd_ok) n_state = ST_WRITE;
                else if (r_item.func == FUNC_READ) n_state = ST_OUT;
                else n_state = ST_WRITE;
            end
            ST_WRITE: begin
                w_mwe   = 1'b1;
                w_mdata = (r_item.func == FUNC_READ) ? '0 : w_inc;
                n_state = ST_OUT;
            end
            ST_OUT: if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // counter memory, one port, registered read held until the next read
    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mem[w_maddr] <= w_mdata;
        if (w_mre) r_rdata <= r_mem[w_maddr];
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_rmax    <= '0;
            r_ovalid  <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_OUT && (!r_ovalid || o_out.ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            r_started <= (r_state == ST_DIV) && (r_started || w_kick);
            unique case (r_state)
                ST_IDLE: if (w_take) begin
                    r_item <= i_in.data;
                    r_addr <= {i_in.data.channel[CH_W-1:0], i_in.data.read_bin[BIN_W-1:0]};
                end
                ST_DIV: if (r_started && w_done) begin
                    r_q    <= w_qadj[BIN_W-1:0];
                    r_addr <= {r_item.channel[CH_W-1:0], w_qadj[BIN_W-1:0]};
                end
                ST_OUT: if (!r_ovalid || o_out.ready) begin
                    r_res.out_of_range <= (r_item.func == FUNC_ACC) && w_oor;
                    if (r_item.func == FUNC_READ) begin
                        r_res.bin_index <= r_item.read_bin;
                        r_res.max_seen  <= w_mbase;
                        r_rmax          <= w_mbase;
                        r_res.bin_count <= w_rd_ok ? r_rdata : '0;
                    end else if (w_oor || !w_ch_ok) begin
                        r_res.bin_index <= '0;
                        r_res.bin_count <= '0;
                        r_res.max_seen  <= w_mbase;
                        r_rmax          <= w_mbase;
                    end else begin
                        r_res.bin_index <= 8'(r_q);
                        r_res.bin_count <= w_inc;
                        r_res.max_seen  <= (w_inc > w_mbase) ? w_inc : w_mbase;
                        r_rmax          <= (w_inc > w_mbase) ? w_inc : w_mbase;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    // a waiting result stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data));

    // nothing is taken during the clearing pass
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_in.ready);

    // divider finishes only for the item that started it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_DIV) && r_started);
endmodule
